// ----- hdl/npcs_pkg.sv -----
// shared types, constants and helpers for the nearest palette color search
// no dependencies

`timescale 1ns / 1ps

package npcs_pkg;

    localparam int PAL_ENTRIES_DEF = 256;
    localparam int RGB_W           = 24;
    localparam int CH_W            = 8;
    localparam int SQ_W            = 2 * CH_W;
    localparam int SCORE_W         = 18;
    localparam int IDX_W           = 8;

    // above every possible distance, so entry 0 always wins first
    localparam logic [SCORE_W-1:0] SCORE_START = SCORE_W'(3 * 256 * 256 + 1);

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_MATCH = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // tag that travels with each palette read through the scoring pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } scan_tag_t;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        logic [CH_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

endpackage

// ----- hdl/nearest_palette_color_search.sv -----
// nearest palette color search: palette ram, scan sequencer, scoring pipeline
// after reset a clearing pass writes zero to all PALETTE_ENTRIES entries, one a cycle,
// and no beat is accepted until it ends
// a write beat is written to the ram as it is accepted; a match beat scans every entry, then gives its result,
// one entry read per cycle on the single ram read port
// next beat is accepted once the result sits in the output register
// depends on npcs_pkg, npcs_palette_ram, npcs_scorer

`timescale 1ns / 1ps

module nearest_palette_color_search
    import npcs_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_func,
    input  logic [IDX_W-1:0] s_entry_index,
    input  logic [RGB_W-1:0] s_color_rgb,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [IDX_W-1:0] m_match_index
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

    state_t state_reg, state_next;
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic [RGB_W-1:0] target_reg, target_next;
    logic             m_valid_reg, m_valid_next;
    logic [IDX_W-1:0] m_index_reg, m_index_next;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [RGB_W-1:0] wr_data;
    logic [RGB_W-1:0] rd_data;
    scan_tag_t        issue_tag;
    logic [AW-1:0]    best_idx;
    logic             done;
    logic             accept;
    logic             cnt_last;
    logic             in_range;

    npcs_palette_ram #(
        .DEPTH (PALETTE_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    npcs_scorer #(
        .AW (AW)
    ) u_scorer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .issue_tag  (issue_tag),
        .issue_idx  (cnt_reg),
        .target_rgb (target_reg),
        .pal_rgb    (rd_data),
        .best_idx   (best_idx),
        .done       (done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        target_reg  <= target_next;
        m_index_reg <= m_index_next;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        target_next  = target_reg;
        m_index_next = m_index_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = AW'(s_entry_index);
        wr_data      = s_color_rgb;
        issue_tag    = '0;
        cnt_last     = (cnt_reg == LAST_ADDR);
        in_range     = (32'(s_entry_index) < 32'(PALETTE_ENTRIES));
        accept       = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg;
                wr_data  = '0;
                cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
                if (cnt_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                accept  = s_valid;
                if (accept && (s_func == FUNC_WRITE)) begin
                    // entries beyond the palette are dropped
                    wr_en = in_range;
                end
                if (accept && (s_func == FUNC_MATCH)) begin
                    target_next = s_color_rgb;
                    cnt_next    = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                issue_tag.valid = 1'b1;
                issue_tag.first = (cnt_reg == '0);
                issue_tag.last  = cnt_last;
                cnt_next        = cnt_last ? '0 : cnt_reg + 1'b1;
                if (cnt_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_index_next = IDX_W'(best_idx);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_match_index = m_index_reg;

endmodule

// ----- hdl/npcs_palette_ram.sv -----
// palette storage: one write port, one read port with registered data
// depends on npcs_pkg

`timescale 1ns / 1ps

module npcs_palette_ram
    import npcs_pkg::*;
#(
    parameter int DEPTH = PAL_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [RGB_W-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [RGB_W-1:0] rd_data
);

    logic [RGB_W-1:0] mem [DEPTH];
    logic [RGB_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/npcs_scorer.sv -----
// distance scoring pipeline: channel squares, then sum and running minimum
// depends on npcs_pkg

`timescale 1ns / 1ps

module npcs_scorer
    import npcs_pkg::*;
#(
    parameter int AW = $clog2(PAL_ENTRIES_DEF)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  scan_tag_t        issue_tag,
    input  logic [AW-1:0]    issue_idx,
    input  logic [RGB_W-1:0] target_rgb,
    input  logic [RGB_W-1:0] pal_rgb,
    output logic [AW-1:0]    best_idx,
    output logic             done
);

    scan_tag_t       tag0_reg, tag1_reg;
    logic [AW-1:0]   idx0_reg, idx1_reg;
    logic [SQ_W-1:0] sq_r_reg, sq_g_reg, sq_b_reg;
    logic [SQ_W-1:0] sq_r_next, sq_g_next, sq_b_next;

    logic [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [AW-1:0]      best_idx_reg, best_idx_next;
    logic               done_reg, done_next;

    logic [SCORE_W-1:0] sum;
    logic [SCORE_W-1:0] ref_score;
    logic [CH_W-1:0]    d_r, d_g, d_b;

    // align tag with registered ram data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag0_reg <= '0;
            tag1_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            tag0_reg <= issue_tag;
            tag1_reg <= tag0_reg;
            done_reg <= done_next;
        end
    end

    always_comb begin
        d_r = abs_diff(target_rgb[7:0],   pal_rgb[7:0]);
        d_g = abs_diff(target_rgb[15:8],  pal_rgb[15:8]);
        d_b = abs_diff(target_rgb[23:16], pal_rgb[23:16]);
        sq_r_next = SQ_W'(d_r) * SQ_W'(d_r);
        sq_g_next = SQ_W'(d_g) * SQ_W'(d_g);
        sq_b_next = SQ_W'(d_b) * SQ_W'(d_b);
    end

    always_ff @(posedge aclk) begin
        idx0_reg       <= issue_idx;
        idx1_reg       <= idx0_reg;
        sq_r_reg       <= sq_r_next;
        sq_g_reg       <= sq_g_next;
        sq_b_reg       <= sq_b_next;
        best_score_reg <= best_score_next;
        best_idx_reg   <= best_idx_next;
    end

    always_comb begin
        sum = SCORE_W'(sq_r_reg) + SCORE_W'(sq_g_reg) + SCORE_W'(sq_b_reg);
        ref_score = tag1_reg.first ? SCORE_START : best_score_reg;
        best_score_next = best_score_reg;
        best_idx_next   = best_idx_reg;
        // strict less than keeps the lowest index on ties
        if (tag1_reg.valid && (sum < ref_score)) begin
            best_score_next = sum;
            best_idx_next   = idx1_reg;
        end
        done_next = tag1_reg.valid && tag1_reg.last;
    end

    assign best_idx = best_idx_reg;
    assign done     = done_reg;

endmodule

// ----- verif/nearest_palette_color_search_test.sv -----
// self-checking bench for nearest_palette_color_search: palette write and match beats
// with random idling on both channels, checked against a scoreboard with its own palette copy
// depends on npcs_pkg and the nearest_palette_color_search rtl

`timescale 1ns / 1ps

class palette_match_scoreboard;

    localparam int SCORE_INIT = 3 * 256 * 256 + 1;
    localparam int ENTRIES    = 256;

    logic [npcs_pkg::RGB_W-1:0] palette [ENTRIES];
    logic [npcs_pkg::IDX_W-1:0] expected_index [$];
    int                         errors;

    function new();
        foreach (palette[i]) palette[i] = '0;
        errors = 0;
    endfunction

    // squared euclidean distance to every entry, strict less-than keeps the lowest index
    function logic [npcs_pkg::IDX_W-1:0] nearest_entry(logic [npcs_pkg::RGB_W-1:0] color);
        int                         best_score;
        int                         score;
        int                         d;
        logic [npcs_pkg::IDX_W-1:0] best;
        best_score = SCORE_INIT;
        best = '0;
        for (int e = 0; e < ENTRIES; e++) begin
            score = 0;
            for (int c = 0; c < 3; c++) begin
                d = int'(color[8*c +: 8]) - int'(palette[e][8*c +: 8]);
                score += d * d;
            end
            if (score < best_score) begin
                best_score = score;
                best = e[npcs_pkg::IDX_W-1:0];
            end
        end
        return best;
    endfunction

    function void note_beat(logic func, logic [npcs_pkg::IDX_W-1:0] idx,
                            logic [npcs_pkg::RGB_W-1:0] color);
        if (func == npcs_pkg::FUNC_WRITE) begin
            palette[idx] = color;
        end else begin
            expected_index.push_back(nearest_entry(color));
        end
    endfunction

    function void check_result(logic [npcs_pkg::IDX_W-1:0] got);
        logic [npcs_pkg::IDX_W-1:0] want;
        if (expected_index.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got match_index %0d",
                     $time, got);
            errors++;
        end else begin
            want = expected_index.pop_front();
            if (got !== want) begin
                $display("%0t: match_index expected %0d, got %0d", $time, want, got);
                errors++;
            end
        end
    endfunction

endclass

module nearest_palette_color_search_test;
    import npcs_pkg::*;

    localparam int SCAN_LATENCY = PAL_ENTRIES_DEF + 4;
    localparam int PHASE_BEATS  = 412;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic             s_func;
    logic [IDX_W-1:0] s_entry_index;
    logic [RGB_W-1:0] s_color_rgb;
    logic             m_valid;
    logic             m_ready;
    logic [IDX_W-1:0] m_match_index;

    int idle_pct  = 0;
    int stall_pct = 0;

    palette_match_scoreboard sb = new();

    nearest_palette_color_search dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_entry_index (s_entry_index),
        .s_color_rgb   (s_color_rgb),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_match_index (m_match_index)
    );

    always #6 aclk = ~aclk;

    // result side: check accepted beats, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_match_index);
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_beat(input logic func, input logic [IDX_W-1:0] idx,
                             input logic [RGB_W-1:0] color);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid       <= 1'b1;
        s_func        <= func;
        s_entry_index <= idx;
        s_color_rgb   <= color;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(func, idx, color);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.expected_index.size() != 0) @(posedge aclk);
        repeat (SCAN_LATENCY + 8) @(posedge aclk);
    endtask

    function automatic logic [RGB_W-1:0] nudge(logic [RGB_W-1:0] c, int spread);
        logic [RGB_W-1:0] r;
        int               v;
        for (int ch = 0; ch < 3; ch++) begin
            v = int'(c[8*ch +: 8]) + int'($urandom_range(2 * spread)) - spread;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            r[8*ch +: 8] = v[7:0];
        end
        return r;
    endfunction

    function automatic logic [RGB_W-1:0] extreme_color();
        logic [RGB_W-1:0] r;
        for (int ch = 0; ch < 3; ch++) begin
            case ($urandom_range(2))
                0: r[8*ch +: 8] = 8'h00;
                1: r[8*ch +: 8] = 8'hff;
                default: r[8*ch +: 8] = 8'($urandom);
            endcase
        end
        return r;
    endfunction

    // matches mostly aim at or near existing entries so ties and close calls come up
    task automatic random_beat();
        logic             func;
        logic [IDX_W-1:0] idx;
        logic [RGB_W-1:0] base;
        logic [RGB_W-1:0] color;
        int               pick;
        func = ($urandom_range(99) < 45) ? FUNC_MATCH : FUNC_WRITE;
        pick = $urandom_range(99);
        idx  = (pick < 5) ? 8'h00 : (pick < 10) ? 8'hff : 8'($urandom);
        base = sb.palette[$urandom_range(255)];
        pick = $urandom_range(99);
        if (func == FUNC_MATCH) begin
            if (pick < 30)      color = base;
            else if (pick < 60) color = nudge(base, $urandom_range(1, 12));
            else if (pick < 80) color = 24'($urandom);
            else                color = extreme_color();
        end else begin
            if (pick < 35)      color = 24'($urandom);
            else if (pick < 60) color = base;
            else if (pick < 80) color = nudge(base, $urandom_range(1, 4));
            else                color = extreme_color();
        end
        send_beat(func, idx, color);
    endtask

    initial begin
        s_valid       <= 1'b0;
        s_func        <= FUNC_WRITE;
        s_entry_index <= '0;
        s_color_rgb   <= '0;
        aresetn       <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all-zero palette answers entry 0, even for the farthest color
        send_beat(FUNC_MATCH, 8'h00, 24'h123456);
        send_beat(FUNC_MATCH, 8'hff, 24'hffffff);
        send_beat(FUNC_WRITE, 8'hff, 24'hffffff);
        send_beat(FUNC_MATCH, 8'h00, 24'hffffff);
        send_beat(FUNC_MATCH, 8'h00, 24'h000000);
        send_beat(FUNC_WRITE, 8'h00, 24'h0000ff);
        send_beat(FUNC_WRITE, 8'h01, 24'h00ff00);
        send_beat(FUNC_WRITE, 8'h02, 24'hff0000);
        send_beat(FUNC_MATCH, 8'h00, 24'h0000ff);
        send_beat(FUNC_MATCH, 8'h00, 24'h00ff00);
        send_beat(FUNC_MATCH, 8'h00, 24'hff0000);
        // exact tie between two entries, lower index wins
        send_beat(FUNC_WRITE, 8'h80, 24'h808080);
        send_beat(FUNC_WRITE, 8'h40, 24'h808080);
        send_beat(FUNC_MATCH, 8'hff, 24'h808080);
        // equal distance from either side
        send_beat(FUNC_WRITE, 8'h65, 24'h0e0e0e);
        send_beat(FUNC_WRITE, 8'h64, 24'h101010);
        send_beat(FUNC_MATCH, 8'haa, 24'h0f0f0f);
        send_beat(FUNC_MATCH, 8'h55, 24'h7f7f7f);
        send_beat(FUNC_WRITE, 8'h00, 24'h000000);
        send_beat(FUNC_MATCH, 8'h00, 24'h010101);
        send_beat(FUNC_WRITE, 8'hfe, 24'hfefefe);
        send_beat(FUNC_MATCH, 8'h00, 24'hfffffe);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            repeat (PHASE_BEATS) random_beat();
            drain_results();
        end

        if (sb.errors == 0 && sb.expected_index.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("%0t: timed out with %0d results outstanding", $time,
                 sb.expected_index.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
